>>> hw/rtl/hosc_pkg.sv
// Shared constants for the hashed owner slot claim block.
// No dependencies; every other file of the block refers to it by scoped names.
package hosc_pkg;

    localparam int unsigned KEY_W          = 64;
    localparam int unsigned HALF_W         = KEY_W / 2;
    localparam int unsigned SLOT_INDEX_W   = 8;
    localparam int unsigned SLOT_COUNT_DEF = 256;

    // Fibonacci hashing multiplier (2^64 divided by the golden ratio)
    localparam logic [KEY_W-1:0] GOLDEN_MUL = 64'h9e37_79b9_7f4a_7c15;

endpackage

>>> hw/rtl/hosc_ifs.sv
// Handshake interfaces for the query and answer channels.
// Depends on hosc_pkg for field widths.
interface hosc_query_if;
    logic                         valid;
    logic                         ready;
    logic [hosc_pkg::KEY_W-1:0]   owner_key;

    modport source (output valid, output owner_key, input ready);
    modport sink   (input valid, input owner_key, output ready);
endinterface

interface hosc_answer_if;
    logic                               valid;
    logic                               ready;
    logic [hosc_pkg::SLOT_INDEX_W-1:0]  slot_index;
    logic                               newly_claimed;
    logic                               table_full;

    modport source (output valid, output slot_index, output newly_claimed,
                    output table_full, input ready);
    modport sink   (input valid, input slot_index, input newly_claimed,
                    input table_full, output ready);
endinterface

>>> hw/rtl/hashed_owner_slot_claim.sv
// Hashed owner slot claim: Fibonacci hash, then linear probe of the owner store.
// Depends on hosc_pkg, hosc_ifs (channels) and hosc_owner_ram (owner store).
//
//   channel | dir | payload                                  | handshake
//   --------+-----+------------------------------------------+-------------
//   query   | in  | owner_key[63:0]                          | valid/ready
//   answer  | out | slot_index[7:0], newly_claimed, table_full | valid/ready
//
// One query runs the hashing steps and then P probes, P being the number of
// slots probed (1 to SLOT_COUNT): three passes through one shared 32x32
// multiplier plus a home slot step, then a read and a compare per probe on
// the store's read port. After reset a clearing pass zeroes every slot of
// the store; query ready stays low meanwhile. The answer sits in an output
// register; a new query is taken while it waits, and a finished lookup holds
// if the register is still occupied.
module hashed_owner_slot_claim #(
    parameter int unsigned SLOT_COUNT = hosc_pkg::SLOT_COUNT_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    hosc_query_if.sink     query,
    hosc_answer_if.source  answer
);

    localparam int unsigned IW     = $clog2(SLOT_COUNT);
    localparam int unsigned KW     = hosc_pkg::KEY_W;
    localparam int unsigned HW     = hosc_pkg::HALF_W;
    localparam logic [IW-1:0] LAST = IW'(SLOT_COUNT - 1);

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_MUL0  = 8'b0000_0100,
        S_MUL1  = 8'b0000_1000,
        S_MUL2  = 8'b0001_0000,
        S_HOME  = 8'b0010_0000,
        S_READ  = 8'b0100_0000,
        S_CMP   = 8'b1000_0000
    } state_t;

    state_t               state_reg, state_next;
    logic [KW-1:0]        key_reg, key_next;
    logic [2*HW-1:0]      mul_reg, mul_next;
    logic [HW-1:0]        acc_reg, acc_next;
    logic [IW-1:0]        idx_reg, idx_next;
    logic [IW-1:0]        probe_reg, probe_next;
    logic [IW-1:0]        clr_reg, clr_next;

    logic                 out_valid_reg, out_valid_next;
    logic [hosc_pkg::SLOT_INDEX_W-1:0] out_index_reg, out_index_next;
    logic                 out_new_reg, out_new_next;
    logic                 out_full_reg, out_full_next;

    logic [HW-1:0]        mul_a, mul_b;
    logic [HW-1:0]        hash_hi;
    logic [IW-1:0]        hash_top;
    logic [IW-1:0]        home;
    logic                 out_free;

    logic                 ram_we, ram_re;
    logic [IW-1:0]        ram_waddr;
    logic [KW-1:0]        ram_wdata;
    logic [KW-1:0]        ram_rdata;
    logic                 hit_match, hit_empty, last_probe;

    hosc_owner_ram #(
        .DEPTH  (SLOT_COUNT),
        .ADDR_W (IW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    // shared multiplier operand select
    always_comb
    begin
        mul_a = key_reg[HW-1:0];
        mul_b = hosc_pkg::GOLDEN_MUL[HW-1:0];
        unique case (state_reg)
            S_MUL1:
            begin
                mul_a = key_reg[HW-1:0];
                mul_b = hosc_pkg::GOLDEN_MUL[KW-1:HW];
            end
            S_MUL2:
            begin
                mul_a = key_reg[KW-1:HW];
                mul_b = hosc_pkg::GOLDEN_MUL[HW-1:0];
            end
            default:
            begin
                mul_a = key_reg[HW-1:0];
                mul_b = hosc_pkg::GOLDEN_MUL[HW-1:0];
            end
        endcase
    end

    // upper half of the 64-bit product, then fold the top bits into range
    assign hash_hi  = acc_reg + mul_reg[HW-1:0];
    assign hash_top = hash_hi[HW-1 -: IW];
    assign home     = ({1'b0, hash_top} >= (IW+1)'(SLOT_COUNT))
                      ? IW'({1'b0, hash_top} - (IW+1)'(SLOT_COUNT)) : hash_top;

    assign hit_match  = (ram_rdata == key_reg);
    assign hit_empty  = (ram_rdata == '0);
    assign last_probe = (probe_reg == LAST);
    assign out_free   = !out_valid_reg || answer.ready;

    always_comb
    begin
        state_next     = state_reg;
        key_next       = key_reg;
        mul_next       = mul_reg;
        acc_next       = acc_reg;
        idx_next       = idx_reg;
        probe_next     = probe_reg;
        clr_next       = clr_reg;
        out_valid_next = out_valid_reg;
        out_index_next = out_index_reg;
        out_new_next   = out_new_reg;
        out_full_next  = out_full_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        ram_waddr      = idx_reg;
        ram_wdata      = key_reg;

        if (out_valid_reg && answer.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == LAST)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (query.valid)
                begin
                    key_next   = query.owner_key;
                    state_next = S_MUL0;
                end
            end
            S_MUL0:
            begin
                mul_next   = mul_a * mul_b;
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                mul_next   = mul_a * mul_b;
                acc_next   = mul_reg[2*HW-1:HW];
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                mul_next   = mul_a * mul_b;
                acc_next   = acc_reg + mul_reg[HW-1:0];
                state_next = S_HOME;
            end
            S_HOME:
            begin
                idx_next   = home;
                probe_next = '0;
                state_next = S_READ;
            end
            S_READ:
            begin
                ram_re     = 1'b1;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (hit_match || hit_empty || last_probe)
                begin
                    // hold until the answer register frees up
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        if (hit_match || hit_empty)
                        begin
                            out_index_next = hosc_pkg::SLOT_INDEX_W'(idx_reg);
                            out_new_next   = !hit_match;
                            out_full_next  = 1'b0;
                            ram_we         = !hit_match;
                        end
                        else
                        begin
                            out_index_next = '0;
                            out_new_next   = 1'b0;
                            out_full_next  = 1'b1;
                        end
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    idx_next   = (idx_reg == LAST) ? '0 : idx_reg + 1'b1;
                    probe_next = probe_reg + 1'b1;
                    state_next = S_READ;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg       <= key_next;
        mul_reg       <= mul_next;
        acc_reg       <= acc_next;
        idx_reg       <= idx_next;
        probe_reg     <= probe_next;
        out_index_reg <= out_index_next;
        out_new_reg   <= out_new_next;
        out_full_reg  <= out_full_next;
    end

    assign query.ready          = (state_reg == S_IDLE);
    assign answer.valid         = out_valid_reg;
    assign answer.slot_index    = out_index_reg;
    assign answer.newly_claimed = out_new_reg;
    assign answer.table_full    = out_full_reg;

endmodule

>>> hw/rtl/hosc_owner_ram.sv
// Owner store: one write port, one registered read port.
// Depends on hosc_pkg for the key width.
module hosc_owner_ram #(
    parameter int unsigned DEPTH  = hosc_pkg::SLOT_COUNT_DEF,
    parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  logic                        clk,
    input  logic                        we,
    input  logic [ADDR_W-1:0]           waddr,
    input  logic [hosc_pkg::KEY_W-1:0]  wdata,
    input  logic                        re,
    input  logic [ADDR_W-1:0]           raddr,
    output logic [hosc_pkg::KEY_W-1:0]  rdata
);

    logic [hosc_pkg::KEY_W-1:0] mem [DEPTH];
    logic [hosc_pkg::KEY_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/hosc_checker.sv
// Port-level checks for hashed_owner_slot_claim, attached by bind.
// Depends on hosc_pkg for field widths.
module hosc_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_ready,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic [hosc_pkg::SLOT_INDEX_W-1:0]  slot_index,
    input logic                               newly_claimed,
    input logic                               table_full
);

    // a full table reports no slot and claims nothing
    a_full_answer: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && table_full) |-> (!newly_claimed && slot_index == '0))
        else $error("full-table answer carries a slot or a claim");

    // the lookup is busy right after a query beat
    a_busy_after_query: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("query ready high right after a query beat");

    // no answer rises during the hashing steps after a query beat
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |-> ##1 !$rose(out_valid) ##1 !$rose(out_valid)
            ##1 !$rose(out_valid) ##1 !$rose(out_valid))
        else $error("answer appeared too soon after a query beat");

    // a stalled answer beat holds
    a_answer_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(slot_index)
            && $stable(newly_claimed) && $stable(table_full)))
        else $error("stalled answer beat changed");

endmodule

bind hashed_owner_slot_claim hosc_checker u_hosc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (query.valid),
    .in_ready      (query.ready),
    .out_valid     (answer.valid),
    .out_ready     (answer.ready),
    .slot_index    (answer.slot_index),
    .newly_claimed (answer.newly_claimed),
    .table_full    (answer.table_full)
);

>>> sim/hashed_owner_slot_claim_tb.sv
// Testbench for hashed_owner_slot_claim: directed and randomized owner lookups checked against an in-bench slot table.
// Depends on hosc_pkg, hosc_ifs and the block's RTL; needs no other files.
`timescale 1ns / 100ps

module hashed_owner_slot_claim_tb;

    localparam int unsigned SLOT_COUNT  = hosc_pkg::SLOT_COUNT_DEF;
    localparam int unsigned INDEX_BITS  = $clog2(SLOT_COUNT);
    localparam int unsigned LOOKUP_MAX  = 4 + 2 * SLOT_COUNT;
    localparam int unsigned STALL_LIMIT = 4000;
    localparam int unsigned PHASE_ITEMS = 450;
    localparam int unsigned HOLD_AFTER  = 150;
    localparam int unsigned HOLD_CYCLES = 400;

    typedef logic [hosc_pkg::KEY_W-1:0] owner_key_t;

    typedef struct packed {
        logic [hosc_pkg::SLOT_INDEX_W-1:0] slot_index;
        logic                              newly_claimed;
        logic                              table_full;
    } slot_answer_t;

    logic clk;
    logic rst_n;

    hosc_query_if  query_ch ();
    hosc_answer_if answer_ch ();

    hashed_owner_slot_claim #(
        .SLOT_COUNT (SLOT_COUNT)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .query  (query_ch),
        .answer (answer_ch)
    );

    owner_key_t   owner_store [SLOT_COUNT] = '{default: '0};
    owner_key_t   pending_keys [$];
    slot_answer_t expected_answers [$];
    owner_key_t   known_keys [$];
    bit           seen_keys [owner_key_t];

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned mismatches;
    int unsigned answers_seen;
    int unsigned hold_left;
    bit          hold_done;
    int unsigned stall_cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int unsigned home_of(owner_key_t key);
        owner_key_t  prod;
        int unsigned top;
        prod = key * hosc_pkg::GOLDEN_MUL;
        top  = (INDEX_BITS == 0) ? 0 : int'(prod >> (hosc_pkg::KEY_W - INDEX_BITS));
        return top % SLOT_COUNT;
    endfunction

    // Find or claim the key's slot, updating the bench copy of the owner store.
    function automatic slot_answer_t claim_slot(owner_key_t key);
        slot_answer_t ans;
        int unsigned  idx;
        int unsigned  n;
        ans = '{slot_index: '0, newly_claimed: 1'b0, table_full: 1'b1};
        idx = home_of(key);
        for (n = 0; n < SLOT_COUNT; n++)
        begin
            if (owner_store[idx] == key)
            begin
                ans = '{slot_index: idx[7:0], newly_claimed: 1'b0, table_full: 1'b0};
                return ans;
            end
            if (owner_store[idx] == '0)
            begin
                owner_store[idx] = key;
                ans = '{slot_index: idx[7:0], newly_claimed: 1'b1, table_full: 1'b0};
                return ans;
            end
            idx = (idx + 1) % SLOT_COUNT;
        end
        return ans;
    endfunction

    function automatic owner_key_t key_with_home(int unsigned target);
        owner_key_t key;
        do
            key = {$urandom, $urandom};
        while (key == '0 || home_of(key) != target);
        return key;
    endfunction

    function automatic owner_key_t patterned_key();
        owner_key_t one_bit;
        one_bit = owner_key_t'(1) << $urandom_range(hosc_pkg::KEY_W - 1);
        case ($urandom_range(3))
            0: return one_bit;
            1: return ~one_bit;
            2: return owner_key_t'($urandom_range(1, 255));
            default: return {$urandom, 32'h0};
        endcase
    endfunction

    function automatic void queue_key(owner_key_t key);
        pending_keys.push_back(key);
        if (key != '0 && !seen_keys.exists(key))
        begin
            seen_keys[key] = 1'b1;
            known_keys.push_back(key);
        end
    endfunction

    // Mostly repeats of known owners; new keys thin out once as many distinct owners as slots have been queued.
    function automatic owner_key_t next_random_key();
        int unsigned r;
        int unsigned new_pct;
        r       = $urandom_range(99);
        new_pct = (seen_keys.num() >= SLOT_COUNT) ? 8 : 40;
        if (r < 5)
            return '0;
        if (r < 5 + new_pct || known_keys.size() == 0)
        begin
            r = $urandom_range(99);
            if (r < 60)
                return {$urandom, $urandom};
            if (r < 85)
                return key_with_home($urandom_range(SLOT_COUNT - 1));
            return patterned_key();
        end
        return known_keys[$urandom_range(known_keys.size() - 1)];
    endfunction

    task automatic wait_drained();
        while (pending_keys.size() != 0 || query_ch.valid || expected_answers.size() != 0)
            @(negedge clk);
    endtask

    // Query driver: predict on every accepted beat, then offer the next key.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            query_ch.valid     <= 1'b0;
            query_ch.owner_key <= '0;
        end
        else
        begin
            if (query_ch.valid && query_ch.ready)
                expected_answers.push_back(claim_slot(query_ch.owner_key));
            if (!query_ch.valid || query_ch.ready)
            begin
                if (pending_keys.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    query_ch.valid     <= 1'b1;
                    query_ch.owner_key <= pending_keys.pop_front();
                end
                else
                    query_ch.valid <= 1'b0;
            end
        end
    end

    // Answer monitor
    always @(posedge clk or negedge rst_n)
    begin : answer_monitor
        slot_answer_t want;
        if (!rst_n)
        begin
            answer_ch.ready <= 1'b0;
            answers_seen    <= 0;
            mismatches      = 0;
        end
        else
        begin
            if (answer_ch.valid && answer_ch.ready)
            begin
                answers_seen <= answers_seen + 1;
                if (expected_answers.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected answer slot=%0d claimed=%b full=%b", $realtime,
                                 answer_ch.slot_index, answer_ch.newly_claimed,
                                 answer_ch.table_full);
                end
                else
                begin
                    want = expected_answers.pop_front();
                    if (answer_ch.slot_index !== want.slot_index
                        || answer_ch.newly_claimed !== want.newly_claimed
                        || answer_ch.table_full !== want.table_full)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: answer mismatch: expected slot=%0d claimed=%b full=%b, got slot=%0d claimed=%b full=%b",
                                     $realtime, want.slot_index, want.newly_claimed,
                                     want.table_full, answer_ch.slot_index,
                                     answer_ch.newly_claimed, answer_ch.table_full);
                    end
                end
            end
            answer_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Hold off the answer side once, long enough for the query side to back up.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && answers_seen == HOLD_AFTER)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stall_cycles <= 0;
        else
        begin
            if ((query_ch.valid && query_ch.ready) || (answer_ch.valid && answer_ch.ready))
                stall_cycles <= 0;
            else if (pending_keys.size() != 0 || query_ch.valid || expected_answers.size() != 0)
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        int unsigned phase;
        owner_key_t  wrap_key;
        owner_key_t  clash_key;
        int unsigned n;

        send_idle_pct = 7;
        recv_idle_pct = 76;
        rst_n <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        for (phase = 0; phase < 3; phase++)
        begin
            @(negedge clk);
            case (phase)
                0:
                begin
                    send_idle_pct = 7;
                    recv_idle_pct = 76;
                end
                1:
                begin
                    send_idle_pct = 76;
                    recv_idle_pct = 7;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase

            if (phase == 0)
            begin
                // zero key on an empty table, key extremes, a repeat hit
                queue_key('0);
                queue_key('1);
                queue_key(owner_key_t'(1));
                queue_key({1'b1, {(hosc_pkg::KEY_W - 1){1'b0}}});
                queue_key('1);
                queue_key({32{2'b10}});
                queue_key({32{2'b01}});
                queue_key({32'h0, 32'hFFFF_FFFF});
                queue_key({32'hFFFF_FFFF, 32'h0});
                // three owners sharing one home slot, then the last again
                for (n = 0; n < 3; n++)
                begin
                    clash_key = key_with_home(SLOT_COUNT / 2);
                    queue_key(clash_key);
                end
                queue_key(clash_key);
                // walk off the last slot and wrap to the bottom
                for (n = 0; n < 3; n++)
                begin
                    wrap_key = key_with_home(SLOT_COUNT - 1);
                    queue_key(wrap_key);
                end
                queue_key(wrap_key);
                // zero key once the low slots are taken
                queue_key('0);
            end

            repeat (PHASE_ITEMS) queue_key(next_random_key());
            wait_drained();
        end

        repeat (LOOKUP_MAX) @(negedge clk);
        if (mismatches == 0 && expected_answers.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/hosc_pkg.sv
hw/rtl/hosc_ifs.sv
hw/rtl/hosc_owner_ram.sv
hw/rtl/hashed_owner_slot_claim.sv
hw/rtl/hosc_checker.sv
sim/hashed_owner_slot_claim_tb.sv
